### rtl/sqch_pkg.sv
// Shared types, codes and helper functions for the square-wave sound channel.
package sqch_pkg;

  localparam int OP_W   = 3;
  localparam int SEL_W  = 3;
  localparam int DATA_W = 8;
  localparam int LVL_W  = 4;
  localparam int FREQ_W = 11;
  localparam int PER_W  = 14;
  localparam int LEN_W  = 7;

  localparam logic [OP_W-1:0] OP_FREQ_TICK = 3'd0;
  localparam logic [OP_W-1:0] OP_LEN_TICK  = 3'd1;
  localparam logic [OP_W-1:0] OP_ENV_TICK  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

  localparam logic [SEL_W-1:0] REG_SWEEP    = 3'd0;
  localparam logic [SEL_W-1:0] REG_DUTY_LEN = 3'd1;
  localparam logic [SEL_W-1:0] REG_ENVELOPE = 3'd2;
  localparam logic [SEL_W-1:0] REG_FREQ_LO  = 3'd3;
  localparam logic [SEL_W-1:0] REG_FREQ_HI  = 3'd4;

  localparam logic [FREQ_W:0] FREQ_BASE = 12'd2048;
  localparam logic [LEN_W-1:0] LEN_FULL = 7'd64;
  localparam logic [LVL_W-1:0] VOL_MAX  = 4'd15;

  localparam logic [7:0] DUTY_TABLE [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SEL_W-1:0]  reg_select;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [LVL_W-1:0]  sample;
    logic [DATA_W-1:0] read_data;
  } result_t;

  function automatic logic [PER_W-1:0] reload_period(input logic [FREQ_W-1:0] f);
    logic [FREQ_W:0] d;
    d = FREQ_BASE - {1'b0, f};
    return {d, 2'b00};
  endfunction

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] pat;
    pat = DUTY_TABLE[sel];
    return pat[~pos];
  endfunction

endpackage

### rtl/sqch_if.sv
// Request and result channel interfaces for the square-wave sound channel.
interface sqch_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [2:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, output opcode, output reg_select, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input reg_select, input write_data,
                output ready);
endinterface

interface sqch_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] sample;
  logic [7:0] read_data;

  modport source (output valid, output sample, output read_data, input ready);
  modport sink (input valid, input sample, input read_data, output ready);
endinterface

### rtl/sqch_in_stage.sv
// Input register holding one request until the core consumes it.
module sqch_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  sqch_in_if.sink        in_chan,
  input  logic           advance,
  output sqch_pkg::item_t item,
  output logic           item_valid
);
  import sqch_pkg::*;

  logic  v_r;
  logic  v_nxt;
  item_t item_r;
  logic  accept;

  assign in_chan.ready = !v_r || advance;
  assign accept        = in_chan.valid && in_chan.ready;
  assign item          = item_r;
  assign item_valid    = v_r;

  always_comb begin
    v_nxt = v_r;
    if (accept) begin
      v_nxt = 1'b1;
    end else if (advance) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{opcode: in_chan.opcode, reg_select: in_chan.reg_select,
                  write_data: in_chan.write_data};
    end
  end

endmodule

### rtl/sqch_core.sv
// Channel state and the update for one request, registered when the request advances.
module sqch_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  sqch_pkg::item_t  item,
  output sqch_pkg::result_t result
);
  import sqch_pkg::*;

  logic [PER_W-1:0]  period_r,    period_nxt;
  logic [2:0]        duty_pos_r,  duty_pos_nxt;
  logic [LVL_W-1:0]  level_r,     level_nxt;
  logic              chan_on_r,   chan_on_nxt;
  logic              dac_on_r,    dac_on_nxt;
  logic [LEN_W-1:0]  len_r,       len_nxt;
  logic              len_stop_r,  len_stop_nxt;
  logic [1:0]        duty_sel_r,  duty_sel_nxt;
  logic [LVL_W-1:0]  vol_r,       vol_nxt;
  logic [LVL_W-1:0]  vol_init_r,  vol_init_nxt;
  logic              env_up_r,    env_up_nxt;
  logic [2:0]        env_per_r,   env_per_nxt;
  logic [3:0]        env_cnt_r,   env_cnt_nxt;
  logic              env_run_r,   env_run_nxt;
  logic [7:0]        freq_lo_r,   freq_lo_nxt;
  logic [2:0]        freq_hi_r,   freq_hi_nxt;
  logic [6:0]        sweep_r,     sweep_nxt;

  logic [2:0]        pos_step;
  logic [LEN_W-1:0]  len_dec;
  logic [LVL_W-1:0]  vol_step;
  logic [DATA_W-1:0] rd;
  logic [DATA_W-1:0] wd;

  assign wd       = item.write_data;
  assign pos_step = duty_pos_r + 3'd1;
  assign len_dec  = len_r - 7'd1;

  always_comb begin
    vol_step = vol_r;
    if (env_run_r && env_per_r != 3'd0) begin
      if (env_up_r && vol_r != VOL_MAX) begin
        vol_step = vol_r + 4'd1;
      end else if (!env_up_r && vol_r != 4'd0) begin
        vol_step = vol_r - 4'd1;
      end
    end
  end

  always_comb begin
    period_nxt   = period_r;
    duty_pos_nxt = duty_pos_r;
    level_nxt    = level_r;
    chan_on_nxt  = chan_on_r;
    dac_on_nxt   = dac_on_r;
    len_nxt      = len_r;
    len_stop_nxt = len_stop_r;
    duty_sel_nxt = duty_sel_r;
    vol_nxt      = vol_r;
    vol_init_nxt = vol_init_r;
    env_up_nxt   = env_up_r;
    env_per_nxt  = env_per_r;
    env_cnt_nxt  = env_cnt_r;
    env_run_nxt  = env_run_r;
    freq_lo_nxt  = freq_lo_r;
    freq_hi_nxt  = freq_hi_r;
    sweep_nxt    = sweep_r;
    rd           = '0;
    case (item.opcode)
      OP_FREQ_TICK: begin
        if (period_r <= 14'd1) begin
          period_nxt   = reload_period({freq_hi_r, freq_lo_r});
          duty_pos_nxt = pos_step;
          level_nxt    = (duty_bit(duty_sel_r, pos_step) && chan_on_r && dac_on_r) ?
                         vol_r : 4'd0;
        end else begin
          period_nxt = period_r - 14'd1;
        end
      end
      OP_LEN_TICK: begin
        if (len_r != '0) begin
          len_nxt = len_dec;
          if (len_dec == '0 && len_stop_r) begin
            chan_on_nxt = 1'b0;
          end
        end
      end
      OP_ENV_TICK: begin
        if (env_cnt_r <= 4'd1) begin
          env_cnt_nxt = {1'b0, env_per_r};
          vol_nxt     = vol_step;
          if (vol_step == 4'd0 || vol_step == VOL_MAX) begin
            env_run_nxt = 1'b0;
          end
        end else begin
          env_cnt_nxt = env_cnt_r - 4'd1;
        end
      end
      OP_WRITE: begin
        case (item.reg_select)
          REG_SWEEP: begin
            sweep_nxt = wd[6:0];
          end
          REG_DUTY_LEN: begin
            duty_sel_nxt = wd[7:6];
            len_nxt      = {1'b0, wd[5:0]};
          end
          REG_ENVELOPE: begin
            dac_on_nxt   = wd[7:3] != 5'd0;
            vol_init_nxt = wd[7:4];
            vol_nxt      = wd[7:4];
            env_up_nxt   = wd[3];
            env_per_nxt  = wd[2:0];
            env_cnt_nxt  = {1'b0, wd[2:0]};
          end
          REG_FREQ_LO: begin
            freq_lo_nxt = wd;
          end
          REG_FREQ_HI: begin
            freq_hi_nxt  = wd[2:0];
            len_stop_nxt = wd[6];
            if (wd[7]) begin
              chan_on_nxt = 1'b1;
              if (len_r == '0) begin
                len_nxt = LEN_FULL;
              end
              period_nxt  = reload_period({wd[2:0], freq_lo_r});
              env_run_nxt = 1'b1;
              env_cnt_nxt = {1'b0, env_per_r};
              vol_nxt     = vol_init_r;
            end
          end
          default: begin
          end
        endcase
      end
      OP_READ: begin
        case (item.reg_select)
          REG_SWEEP:    rd = {1'b0, sweep_r};
          REG_DUTY_LEN: rd = {duty_sel_r, len_r[5:0]};
          REG_ENVELOPE: rd = {vol_init_r, env_up_r, env_per_r};
          REG_FREQ_LO:  rd = freq_lo_r;
          REG_FREQ_HI:  rd = {1'b0, len_stop_r, 3'b000, freq_hi_r};
          default:      rd = '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign result = '{sample: level_nxt, read_data: rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= '0;
      duty_pos_r <= '0;
      level_r    <= '0;
      chan_on_r  <= 1'b0;
      dac_on_r   <= 1'b0;
      len_r      <= '0;
      len_stop_r <= 1'b0;
      duty_sel_r <= '0;
      vol_r      <= '0;
      vol_init_r <= '0;
      env_up_r   <= 1'b0;
      env_per_r  <= '0;
      env_cnt_r  <= '0;
      env_run_r  <= 1'b0;
      freq_lo_r  <= '0;
      freq_hi_r  <= '0;
      sweep_r    <= '0;
    end else if (advance) begin
      period_r   <= period_nxt;
      duty_pos_r <= duty_pos_nxt;
      level_r    <= level_nxt;
      chan_on_r  <= chan_on_nxt;
      dac_on_r   <= dac_on_nxt;
      len_r      <= len_nxt;
      len_stop_r <= len_stop_nxt;
      duty_sel_r <= duty_sel_nxt;
      vol_r      <= vol_nxt;
      vol_init_r <= vol_init_nxt;
      env_up_r   <= env_up_nxt;
      env_per_r  <= env_per_nxt;
      env_cnt_r  <= env_cnt_nxt;
      env_run_r  <= env_run_nxt;
      freq_lo_r  <= freq_lo_nxt;
      freq_hi_r  <= freq_hi_nxt;
      sweep_r    <= sweep_nxt;
    end
  end

endmodule

### rtl/sqch_out_stage.sv
// Result register presenting one result until the sink takes it.
module sqch_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sqch_pkg::result_t res,
  output logic              can_load,
  sqch_out_if.source        out_chan
);
  import sqch_pkg::*;

  logic    v_r;
  logic    v_nxt;
  result_t res_r;

  assign can_load           = !v_r || out_chan.ready;
  assign out_chan.valid     = v_r;
  assign out_chan.sample    = res_r.sample;
  assign out_chan.read_data = res_r.read_data;

  always_comb begin
    v_nxt = v_r;
    if (load) begin
      v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### rtl/square_wave_sound_channel_unit.sv
// Square-wave sound channel: input register, channel core and result register.
// A request is held in the input register and its result in the result register.
// Throughput: one request per cycle while the result register is not stalled.
// A stalled result register holds the core and the input register.
// Reset (synchronous, rst_n low) clears all channel state and both valid flags.
module square_wave_sound_channel_unit (
  input  logic       clk,
  input  logic       rst_n,
  sqch_in_if.sink    in_chan,
  sqch_out_if.source out_chan
);
  import sqch_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    can_load;
  logic    advance;
  result_t res;

  assign advance = item_valid && can_load;

  sqch_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  sqch_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (res)
  );

  sqch_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .res      (res),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

### sim/square_wave_sound_channel_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the square-wave sound channel unit, with its own channel predictor.
module square_wave_sound_channel_unit_tb;
  import sqch_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_LEN     = 60;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS = 340;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct {
    logic [PER_W-1:0] period_cnt;
    logic [2:0]       duty_pos;
    logic [LVL_W-1:0] level;
    logic             ch_on;
    logic             dac_on;
    logic [LEN_W-1:0] length_cnt;
    logic             length_stop;
    logic [1:0]       duty_sel;
    logic [3:0]       vol;
    logic [3:0]       vol_init;
    logic             env_up;
    logic [2:0]       env_period;
    logic [3:0]       env_cnt;
    logic             env_run;
    logic [7:0]       freq_lo;
    logic [2:0]       freq_hi;
    logic [6:0]       sweep;
  } chan_state_t;

  logic clk;
  logic rst_n;

  sqch_in_if  in_chan ();
  sqch_out_if out_chan ();

  square_wave_sound_channel_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  chan_state_t chan;
  result_t     expected_results [$];
  int          errors;
  int unsigned items_sent;
  int unsigned burst_left;
  bit          pacing = 1'b1;
  int unsigned hold_req_cnt;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PER_W-1:0] period_of(input logic [2:0] hi, input logic [7:0] lo);
    int unsigned f;
    f = 32'({hi, lo});
    return PER_W'((2048 - f) * 4);
  endfunction

  function automatic result_t channel_model(input item_t req);
    result_t    res;
    logic [7:0] rd;
    logic [7:0] pat;
    rd = '0;
    case (req.opcode)
      OP_FREQ_TICK: begin
        if (chan.period_cnt <= 1) begin
          chan.period_cnt = period_of(chan.freq_hi, chan.freq_lo);
          chan.duty_pos   = chan.duty_pos + 3'd1;
          pat = DUTY_TABLE[chan.duty_sel];
          chan.level = (pat[3'd7 - chan.duty_pos] && chan.ch_on && chan.dac_on) ?
                       chan.vol : '0;
        end else begin
          chan.period_cnt = chan.period_cnt - 1'b1;
        end
      end
      OP_LEN_TICK: begin
        if (chan.length_cnt != 0) begin
          chan.length_cnt = chan.length_cnt - 1'b1;
          if (chan.length_cnt == 0 && chan.length_stop) chan.ch_on = 1'b0;
        end
      end
      OP_ENV_TICK: begin
        if (chan.env_cnt <= 1) begin
          chan.env_cnt = {1'b0, chan.env_period};
          if (chan.env_run && chan.env_period != 0) begin
            if (chan.env_up && chan.vol < VOL_MAX) chan.vol = chan.vol + 1'b1;
            else if (!chan.env_up && chan.vol > 0) chan.vol = chan.vol - 1'b1;
          end
          if (chan.vol == 0 || chan.vol == VOL_MAX) chan.env_run = 1'b0;
        end else begin
          chan.env_cnt = chan.env_cnt - 1'b1;
        end
      end
      OP_WRITE: begin
        case (req.reg_select)
          REG_SWEEP: chan.sweep = req.write_data[6:0];
          REG_DUTY_LEN: begin
            chan.duty_sel   = req.write_data[7:6];
            chan.length_cnt = {1'b0, req.write_data[5:0]};
          end
          REG_ENVELOPE: begin
            chan.dac_on     = |req.write_data[7:3];
            chan.vol_init   = req.write_data[7:4];
            chan.vol        = req.write_data[7:4];
            chan.env_up     = req.write_data[3];
            chan.env_period = req.write_data[2:0];
            chan.env_cnt    = {1'b0, req.write_data[2:0]};
          end
          REG_FREQ_LO: chan.freq_lo = req.write_data;
          REG_FREQ_HI: begin
            chan.freq_hi     = req.write_data[2:0];
            chan.length_stop = req.write_data[6];
            if (req.write_data[7]) begin
              chan.ch_on = 1'b1;
              if (chan.length_cnt == 0) chan.length_cnt = LEN_FULL;
              chan.period_cnt = period_of(chan.freq_hi, chan.freq_lo);
              chan.env_run    = 1'b1;
              chan.env_cnt    = {1'b0, chan.env_period};
              chan.vol        = chan.vol_init;
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (req.reg_select)
          REG_SWEEP:    rd = {1'b0, chan.sweep};
          REG_DUTY_LEN: rd = {chan.duty_sel, chan.length_cnt[5:0]};
          REG_ENVELOPE: rd = {chan.vol_init, chan.env_up, chan.env_period};
          REG_FREQ_LO:  rd = chan.freq_lo;
          REG_FREQ_HI:  rd = {1'b0, chan.length_stop, 3'b000, chan.freq_hi};
          default:      rd = '0;
        endcase
      end
      default: ;
    endcase
    res.sample    = chan.level;
    res.read_data = rd;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t exp_res;
    item_t   req;
    if (!rst_n) begin
      chan = '{default: '0};
      expected_results.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got sample %0h read_data %0h",
                   $time, out_chan.sample, out_chan.read_data);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_chan.sample !== exp_res.sample) begin
            $display("%0t: sample mismatch, expected %0h, got %0h",
                     $time, exp_res.sample, out_chan.sample);
            errors++;
          end
          if (out_chan.read_data !== exp_res.read_data) begin
            $display("%0t: read_data mismatch, expected %0h, got %0h",
                     $time, exp_res.read_data, out_chan.read_data);
            errors++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        req.opcode     = in_chan.opcode;
        req.reg_select = in_chan.reg_select;
        req.write_data = in_chan.write_data;
        expected_results.push_back(channel_model(req));
      end
    end
  end

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned phase;
    logic [7:0]  stall_pat;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_seen = 0;
    hold_left = 0;
    phase     = 0;
    stall_pat = '0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_LEN;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
        stall_pat = 8'($urandom);
      end else begin
        mode_left--;
      end
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_chan.ready <= 1'b1;
          RX_RANDOM: out_chan.ready <= ($urandom_range(0, 2) != 0);
          default:   out_chan.ready <= ~stall_pat[phase[2:0]];
        endcase
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still outstanding", $time, expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_req(input logic [2:0] op, input logic [2:0] sel, input logic [7:0] data);
    int unsigned gap;
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= op;
    in_chan.reg_select <= sel;
    in_chan.write_data <= data;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (pacing) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_chan.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_tick_or_read();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)      send_req(OP_FREQ_TICK, 3'($urandom), 8'($urandom));
    else if (r < 75) send_req(OP_LEN_TICK, 3'($urandom), 8'($urandom));
    else if (r < 90) send_req(OP_ENV_TICK, 3'($urandom), 8'($urandom));
    else if (r < 97) send_req(OP_READ, 3'($urandom_range(0, 4)), 8'($urandom));
    else             send_req(OP_WRITE, 3'($urandom_range(0, 7)), 8'($urandom));
  endtask

  task automatic test_reset_readback();
    for (int s = 0; s < 8; s++) send_req(OP_READ, s[2:0], 8'($urandom));
    wait_idle();
  endtask

  task automatic test_directed_extremes();
    send_req(OP_WRITE, REG_SWEEP, 8'hFF);
    send_req(OP_WRITE, REG_DUTY_LEN, 8'hFF);
    send_req(OP_WRITE, REG_ENVELOPE, 8'hF1);
    send_req(OP_WRITE, REG_FREQ_LO, 8'hFF);
    send_req(OP_WRITE, REG_FREQ_HI, 8'hC7);
    send_req(OP_READ, REG_DUTY_LEN, 8'h00);
    send_req(OP_READ, REG_FREQ_HI, 8'h00);
    repeat (6) send_req(OP_FREQ_TICK, REG_SWEEP, 8'h00);
    repeat (2) send_req(OP_ENV_TICK, REG_SWEEP, 8'h00);
    send_req(OP_LEN_TICK, REG_SWEEP, 8'h00);
    send_req(OP_WRITE, 3'd5, 8'hFF);
    send_req(3'd7, 3'd7, 8'hFF);
    send_req(3'd5, REG_SWEEP, 8'h00);
    // run the length out with the stop bit set, then tick at zero
    send_req(OP_WRITE, REG_DUTY_LEN, 8'h01);
    repeat (2) send_req(OP_LEN_TICK, REG_SWEEP, 8'h00);
    send_req(OP_WRITE, REG_ENVELOPE, 8'h00);
    send_req(OP_WRITE, REG_FREQ_HI, 8'h80);
    send_req(OP_READ, REG_DUTY_LEN, 8'h00);
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_req(OP_WRITE, REG_ENVELOPE, 8'hA8);
    send_req(OP_WRITE, REG_FREQ_LO, 8'hFE);
    send_req(OP_WRITE, REG_FREQ_HI, 8'h87);
    pacing = 1'b0;
    hold_req_cnt++;
    repeat (30) send_tick_or_read();
    repeat (40) send_req(OP_FREQ_TICK, REG_SWEEP, 8'($urandom));
    pacing = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_sequences();
    int unsigned target;
    int unsigned n;
    logic [1:0]  duty;
    logic [5:0]  len;
    logic [7:0]  lo;
    logic [7:0]  hi;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      // most sequences set the channel up and restart it; some tick a stale setup
      if ($urandom_range(0, 4) != 0) begin
        duty = 2'($urandom);
        len  = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 4)) : 6'($urandom);
        lo   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hE0, 8'hFF)) : 8'($urandom);
        hi   = 8'($urandom);
        if ($urandom_range(0, 3) != 0) hi[2:0] = 3'h7;
        if ($urandom_range(0, 5) != 0) hi[7] = 1'b1;
        send_req(OP_WRITE, REG_ENVELOPE, 8'($urandom));
        send_req(OP_WRITE, REG_DUTY_LEN, {duty, len});
        if ($urandom_range(0, 3) == 0) send_req(OP_WRITE, REG_SWEEP, 8'($urandom));
        send_req(OP_WRITE, REG_FREQ_LO, lo);
        send_req(OP_WRITE, REG_FREQ_HI, hi);
      end
      n = $urandom_range(10, 40);
      repeat (n) send_tick_or_read();
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
    wait_idle();
  endtask

  task automatic test_noise();
    repeat (60) send_req(3'($urandom), 3'($urandom), 8'($urandom));
    wait_idle();
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.opcode     <= OP_FREQ_TICK;
    in_chan.reg_select <= REG_SWEEP;
    in_chan.write_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_readback();
    test_directed_extremes();
    test_backpressure();
    test_random_sequences();
    test_noise();
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
